/* src/space_vector_pwm_top_defines.svh */
// Assertion macros for the space vector modulator.
`ifndef SPACE_VECTOR_PWM_TOP_DEFINES_SVH
`define SPACE_VECTOR_PWM_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SVP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("svp assertion failed");
`define SVP_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("svp assertion failed");
`else
`define SVP_ASSERT_IMP(label, clk, rst, ante, cons)
`define SVP_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

/* src/svp_pkg.sv */
// ---------------------------------------------------------------------------
// svp_pkg
// Shared constants, types and the sine table of the space vector modulator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package svp_pkg;

   localparam int SINE_ENTRIES   = 256;
   localparam int IDX_W          = $clog2(SINE_ENTRIES);
   localparam int TIME_FRAC_BITS = 4;
   localparam longint unsigned PI3_Q30 = 64'd1124419809;

   // dwell dividend: (ref*s*n) >> (14 - F), quotient width
   localparam int PROD_SHIFT = 14 - TIME_FRAC_BITS;
   localparam int D_W        = 48 - PROD_SHIFT;
   localparam int CNT_W      = $clog2(D_W);
   localparam int BW         = D_W + 6;

   localparam int FIFO_DEPTH = 4;
   localparam int FPTR_W     = $clog2(FIFO_DEPTH);

   localparam logic [15:0] PERIOD_RESET = 16'd100;

   localparam logic [2:0] VEC_ZERO  = 3'd0;
   localparam logic [2:0] VEC_FIRST = 3'd1;
   localparam logic [2:0] VEC_SEVEN = 3'd7;

   localparam logic [1:0] PH_NONE  = 2'd0;
   localparam logic [1:0] PH_LOWER = 2'd1;
   localparam logic [1:0] PH_UPPER = 2'd2;

   typedef logic [15:0] sine_tab_type [0:SINE_ENTRIES];

   typedef struct packed {
      logic [15:0] dc;
      logic [15:0] mag;
      logic [15:0] s_l;
      logic [15:0] s_r;
      logic [2:0]  sec;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_out_type;

   function automatic sine_tab_type build_sine();
      sine_tab_type tab;
      longint unsigned x, x2, term, sum;
      for (int k = 0; k <= SINE_ENTRIES; k++) begin
         x    = (longint'(k) * PI3_Q30) / SINE_ENTRIES;
         x2   = (x * x) >> 30;
         term = x;
         sum  = x;
         term = ((term * x2) >> 30) / 64'd6;
         sum  = (sum >= term) ? sum - term : 64'd0;
         term = ((term * x2) >> 30) / 64'd20;
         sum  = sum + term;
         term = ((term * x2) >> 30) / 64'd42;
         sum  = (sum >= term) ? sum - term : 64'd0;
         term = ((term * x2) >> 30) / 64'd72;
         sum  = sum + term;
         tab[k] = 16'((sum + 64'd16384) >> 15);
      end
      return tab;
   endfunction

   localparam sine_tab_type SINE_TAB = build_sine();

   // phase codes (a, b, c) of one of the eight switching vectors
   function automatic logic [5:0] vec_code(input logic [2:0] v);
      logic [5:0] c;
      case (v)
         3'd0:    c = {PH_LOWER, PH_LOWER, PH_LOWER};
         3'd1:    c = {PH_UPPER, PH_LOWER, PH_LOWER};
         3'd2:    c = {PH_UPPER, PH_UPPER, PH_LOWER};
         3'd3:    c = {PH_LOWER, PH_UPPER, PH_LOWER};
         3'd4:    c = {PH_LOWER, PH_UPPER, PH_UPPER};
         3'd5:    c = {PH_LOWER, PH_LOWER, PH_UPPER};
         3'd6:    c = {PH_UPPER, PH_LOWER, PH_UPPER};
         default: c = {PH_UPPER, PH_UPPER, PH_UPPER};
      endcase
      return c;
   endfunction

endpackage

/* src/space_vector_pwm_top.sv */
// The back takes one tick at a time: the bit-serial dwell divider produces
// one quotient bit per cycle, 38 bits, both dwell times in parallel, and a
// new tick leaves the queue only after the previous response is issued.
// The front accepts up to four ticks ahead of the back through its queue.
// Reset (synchronous, active high) clears the queue, tick counter and held
// phases to no valve on, and loads period_steps with 100.
// ---------------------------------------------------------------------------
// space_vector_pwm_top
// Seven-segment space vector modulator with decoupled front and back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module space_vector_pwm_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // dc_voltage, ref_magnitude, angle
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // phase_a, phase_b, phase_c, zero pad
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data     // period_steps
);

   logic [15:0]            period_ff, period_in;
   svp_pkg::item_type      item;
   svp_pkg::queue_out_type head;
   logic                   full, pop;
   logic [5:0]             phase;

   // period register: always ready; the user must write it only while the block is idle, the block does not enforce it
   assign csr_ready = 1'b1;
   assign period_in = (csr_valid && csr_ready) ? csr_data : period_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= svp_pkg::PERIOD_RESET;
      end else begin
         period_ff <= period_in;
      end
   end

   // front: classify each transaction and queue it
   svp_front u_front (
      .dc_voltage    (req_tdata[15:0]),
      .ref_magnitude (req_tdata[31:16]),
      .angle         (req_tdata[47:32]),
      .item          (item)
   );

   assign req_tready = !full;

   svp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_tvalid),
      .push_item (item),
      .full      (full),
      .pop       (pop),
      .head      (head)
   );

   // back: dwell times, bounds and phase state, one tick at a time
   svp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .period    (period_ff),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_phase (phase)
   );

   // pack phase_a in the lowest bits
   assign rsp_tdata = {2'b00, phase[1:0], phase[3:2], phase[5:4]};

endmodule

/* src/svp_front.sv */
// ---------------------------------------------------------------------------
// svp_front
// Classify one tick: saturate zero DC, find sector and both sine values.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module svp_front (
   input  logic [15:0]       dc_voltage,
   input  logic [15:0]       ref_magnitude,
   input  logic [15:0]       angle,
   output svp_pkg::item_type item
);

   logic [18:0]             p;
   logic [svp_pkg::IDX_W:0] idx;
   logic [svp_pkg::IDX_W:0] idx_r;

   always_comb begin
      p     = {1'b0, angle, 2'b00} + {2'b00, angle, 1'b0};
      idx   = {1'b0, p[15:16-svp_pkg::IDX_W]};
      idx_r = (svp_pkg::IDX_W+1)'(svp_pkg::SINE_ENTRIES) - idx;
      item.sec = p[18:16] + 3'd1;
      item.s_l = svp_pkg::SINE_TAB[idx];
      item.s_r = svp_pkg::SINE_TAB[idx_r];
      // zero DC: saturate the index as for full reference over unit DC
      if (dc_voltage == 16'd0) begin
         item.dc  = 16'd1;
         item.mag = 16'hFFFF;
      end else begin
         item.dc  = dc_voltage;
         item.mag = ref_magnitude;
      end
   end

endmodule

/* src/svp_fifo.sv */
// ---------------------------------------------------------------------------
// svp_fifo
// Short queue of classified ticks between front and back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module svp_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  svp_pkg::item_type        push_item,
   output logic                     full,
   input  logic                     pop,
   output svp_pkg::queue_out_type   head
);

   svp_pkg::item_type              mem_ff [svp_pkg::FIFO_DEPTH];
   logic [svp_pkg::FPTR_W-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [svp_pkg::FPTR_W:0]       cnt_ff, cnt_in;
   logic                           do_push, do_pop;

   always_comb begin
      full       = (cnt_ff == (svp_pkg::FPTR_W+1)'(svp_pkg::FIFO_DEPTH));
      do_push    = push && !full;
      do_pop     = pop && (cnt_ff != '0);
      head.valid = (cnt_ff != '0);
      head.item  = mem_ff[rd_ff];
      wr_in      = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in      = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in     = cnt_ff + {{svp_pkg::FPTR_W{1'b0}}, do_push}
                          - {{svp_pkg::FPTR_W{1'b0}}, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

endmodule

/* src/svp_back.sv */
// ---------------------------------------------------------------------------
// svp_back
// Dwell times, segment bounds and phase selection for one tick at a time.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "space_vector_pwm_top_defines.svh"
module svp_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [15:0]            period,
   input  svp_pkg::queue_out_type head,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [5:0]             rsp_phase
);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_MUL1 = 6'b000010,
      ST_MUL2 = 6'b000100,
      ST_DIV  = 6'b001000,
      ST_BND  = 6'b010000,
      ST_CMP  = 6'b100000
   } state_type;

   localparam int D_W = svp_pkg::D_W;
   localparam int BW  = svp_pkg::BW;

   state_type                  state_ff, state_in;
   svp_pkg::item_type          it_ff, it_in;
   logic [31:0]                pl_ff, pl_in, pr_ff, pr_in;
   logic [D_W-1:0]             ql_ff, ql_in, qr_ff, qr_in;
   logic [16:0]                reml_ff, reml_in, remr_ff, remr_in;
   logic [svp_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic signed [BW-1:0]       b1_ff, b2_ff, b3_ff, b4_ff, b5_ff, b6_ff, be_ff;
   logic signed [BW-1:0]       b1_in, b2_in, b3_in, b4_in, b5_in, b6_in, be_in;
   logic [2:0]                 first_ff, first_in, second_ff, second_in;
   logic [16:0]                tick_ff, tick_in;
   logic [1:0]                 held_ff [3];
   logic [1:0]                 held_in [3];
   logic                       rv_ff, rv_in;
   logic [5:0]                 rd_ff, rd_in;

   logic [47:0]                prod_l, prod_r;
   logic [16:0]                shl, shr;
   logic                       gel, ger, rsp_free;
   logic signed [BW-1:0]       tl, tr, tf, ts, nq, t0, tq;
   logic [16:0]                tc;
   logic [3:0]                 fs, ss;
   logic [2:0]                 sel;
   logic                       sel_ok;
   logic [5:0]                 code;

   always_comb begin
      state_in  = state_ff;
      it_in     = it_ff;
      pl_in     = pl_ff;
      pr_in     = pr_ff;
      ql_in     = ql_ff;
      qr_in     = qr_ff;
      reml_in   = reml_ff;
      remr_in   = remr_ff;
      cnt_in    = cnt_ff;
      b1_in = b1_ff; b2_in = b2_ff; b3_in = b3_ff; b4_in = b4_ff;
      b5_in = b5_ff; b6_in = b6_ff; be_in = be_ff;
      first_in  = first_ff;
      second_in = second_ff;
      tick_in   = tick_ff;
      held_in   = held_ff;
      rd_in     = rd_ff;
      pop       = 1'b0;
      rsp_free  = !rv_ff || rsp_ready;
      rv_in     = rsp_ready ? 1'b0 : rv_ff;

      prod_l = 48'(pl_ff) * 48'(period);
      prod_r = 48'(pr_ff) * 48'(period);
      shl    = {reml_ff[15:0], ql_ff[D_W-1]};
      shr    = {remr_ff[15:0], qr_ff[D_W-1]};
      gel    = shl >= {1'b0, it_ff.dc};
      ger    = shr >= {1'b0, it_ff.dc};

      tl = BW'(ql_ff);
      tr = BW'(qr_ff);
      tf = it_ff.sec[0] ? tr : tl;
      ts = it_ff.sec[0] ? tl : tr;
      nq = BW'({period, {svp_pkg::TIME_FRAC_BITS{1'b0}}});
      t0 = nq - tl - tr;
      fs = it_ff.sec[0] ? {1'b0, it_ff.sec} : {1'b0, it_ff.sec} + 4'd1;
      ss = it_ff.sec[0] ? {1'b0, it_ff.sec} + 4'd1 : {1'b0, it_ff.sec};

      tc = (tick_ff > {1'b0, period}) ? 17'd0 : tick_ff;
      tq = BW'({tc, {(svp_pkg::TIME_FRAC_BITS+2){1'b0}}});
      sel    = svp_pkg::VEC_ZERO;
      sel_ok = 1'b0;
      // later segment wins where overmodulation makes them overlap
      if (tq <= b1_ff) begin
         sel = svp_pkg::VEC_ZERO; sel_ok = 1'b1;
      end
      if (tq > b1_ff && tq <= b2_ff) begin
         sel = first_ff; sel_ok = 1'b1;
      end
      if (tq > b2_ff && tq <= b3_ff) begin
         sel = second_ff; sel_ok = 1'b1;
      end
      if (tq > b3_ff && tq <= b4_ff) begin
         sel = svp_pkg::VEC_SEVEN; sel_ok = 1'b1;
      end
      if (tq > b4_ff && tq <= b5_ff) begin
         sel = second_ff; sel_ok = 1'b1;
      end
      if (tq > b5_ff && tq <= b6_ff) begin
         sel = first_ff; sel_ok = 1'b1;
      end
      if (tq > b6_ff && tq <= be_ff) begin
         sel = svp_pkg::VEC_ZERO; sel_ok = 1'b1;
      end
      code = svp_pkg::vec_code(sel);

      case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               pop      = 1'b1;
               it_in    = head.item;
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            pl_in    = 32'(it_ff.mag) * 32'(it_ff.s_l);
            pr_in    = 32'(it_ff.mag) * 32'(it_ff.s_r);
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            ql_in    = prod_l[47:svp_pkg::PROD_SHIFT];
            qr_in    = prod_r[47:svp_pkg::PROD_SHIFT];
            reml_in  = '0;
            remr_in  = '0;
            cnt_in   = svp_pkg::CNT_W'(D_W - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            reml_in = gel ? shl - {1'b0, it_ff.dc} : shl;
            remr_in = ger ? shr - {1'b0, it_ff.dc} : shr;
            ql_in   = {ql_ff[D_W-2:0], gel};
            qr_in   = {qr_ff[D_W-2:0], ger};
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_BND;
            end
         end
         ST_BND: begin
            b1_in = t0;
            b2_in = t0 + (tf <<< 1);
            b3_in = t0 + (tf <<< 1) + (ts <<< 1);
            b4_in = (t0 <<< 1) + t0 + (tf <<< 1) + (ts <<< 1);
            b5_in = (t0 <<< 1) + t0 + (tf <<< 1) + (ts <<< 2);
            b6_in = (t0 <<< 1) + t0 + (tf <<< 2) + (ts <<< 2);
            be_in = nq <<< 2;
            first_in  = (fs >= 4'd7) ? svp_pkg::VEC_FIRST : fs[2:0];
            second_in = (ss >= 4'd7) ? svp_pkg::VEC_FIRST : ss[2:0];
            state_in  = ST_CMP;
         end
         ST_CMP: begin
            if (rsp_free) begin
               if (sel_ok) begin
                  held_in[0] = code[5:4];
                  held_in[1] = code[3:2];
                  held_in[2] = code[1:0];
               end
               rd_in    = sel_ok ? code : {held_ff[0], held_ff[1], held_ff[2]};
               rv_in    = 1'b1;
               tick_in  = tc + 17'd1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tick_ff  <= '0;
         held_ff  <= '{svp_pkg::PH_NONE, svp_pkg::PH_NONE, svp_pkg::PH_NONE};
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         tick_ff  <= tick_in;
         held_ff  <= held_in;
         rv_ff    <= rv_in;
      end
      it_ff     <= it_in;
      pl_ff     <= pl_in;
      pr_ff     <= pr_in;
      ql_ff     <= ql_in;
      qr_ff     <= qr_in;
      reml_ff   <= reml_in;
      remr_ff   <= remr_in;
      cnt_ff    <= cnt_in;
      b1_ff <= b1_in; b2_ff <= b2_in; b3_ff <= b3_in; b4_ff <= b4_in;
      b5_ff <= b5_in; b6_ff <= b6_in; be_ff <= be_in;
      first_ff  <= first_in;
      second_ff <= second_in;
      rd_ff     <= rd_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_phase = rd_ff;

   `SVP_ASSERT_NXT(a_cmp_emits, clock, reset, (state_ff == ST_CMP) && rsp_free, rv_ff)
   `SVP_ASSERT_NXT(a_div_ends, clock, reset, (state_ff == ST_DIV) && (cnt_ff == '0), state_ff == ST_BND)
   `SVP_ASSERT_IMP(a_held_legal, clock, reset, 1'b1, (held_ff[0] != 2'd3) && (held_ff[1] != 2'd3) && (held_ff[2] != 2'd3))
   `SVP_ASSERT_IMP(a_tick_bound, clock, reset, 1'b1, tick_ff <= 17'd65536)

endmodule

/* sim/space_vector_pwm_top_test.sv */
// ---------------------------------------------------------------------------
// space_vector_pwm_top_test
// Self-checking bench for the seven-segment space vector modulator. A
// directed table covers input extremes, zero DC link voltage, overmodulation
// and sector edges. Random ticks under several period settings follow and
// also wrap the tick counter. Every phase transaction is checked against a
// typed answer or an in-bench model of the tick counter and held phases.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module space_vector_pwm_top_test;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = '0;

   space_vector_pwm_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // model state: period register, tick counter, held phases {a, b, c}
   logic [15:0]     mdl_period;
   logic [16:0]     mdl_tick;
   logic [5:0]      mdl_held;
   logic [15:0]     sine_q15 [0:svp_pkg::SINE_ENTRIES];
   logic [5:0]      phase_queue [$];
   int              error_count = 0;
   int              send_idle_pct = 0;
   int              recv_idle_pct = 0;
   bit              hold_request = 1'b0;

   typedef struct {
      logic [15:0] dc;
      logic [15:0] mag;
      logic [15:0] ang;
      bit          has_exp;
      logic [5:0]  exp;
   } tick_row_type;

   // codes below pack {a, b, c} with a in the low bits as on rsp_tdata
   localparam logic [5:0] ALL_LOWER = {svp_pkg::PH_LOWER, svp_pkg::PH_LOWER,
                                       svp_pkg::PH_LOWER};

   tick_row_type directed [] = '{
      // first tick after reset sits in the leading zero segment
      '{16'd1000, 16'd0, 16'd0, 1'b1, ALL_LOWER},
      '{16'd65535, 16'd65535, 16'd0, 1'b0, 6'd0},
      '{16'd65535, 16'd65535, 16'd65535, 1'b0, 6'd0},
      '{16'd0, 16'd0, 16'd10923, 1'b0, 6'd0},       // zero DC link voltage
      '{16'd0, 16'd65535, 16'd32768, 1'b0, 6'd0},
      '{16'd1, 16'd65535, 16'd5461, 1'b0, 6'd0},    // deep overmodulation
      '{16'd1, 16'd0, 16'd65535, 1'b0, 6'd0},
      '{16'd40000, 16'd10000, 16'd10922, 1'b0, 6'd0}, // sector edges
      '{16'd40000, 16'd10000, 16'd10923, 1'b0, 6'd0},
      '{16'd40000, 16'd10000, 16'd21845, 1'b0, 6'd0},
      '{16'd40000, 16'd10000, 16'd32768, 1'b0, 6'd0},
      '{16'd40000, 16'd10000, 16'd43691, 1'b0, 6'd0},
      '{16'd40000, 16'd10000, 16'd54613, 1'b0, 6'd0},
      '{16'd40000, 16'd20000, 16'd60000, 1'b0, 6'd0},
      '{16'd40000, 16'd23000, 16'd3000, 1'b0, 6'd0},
      '{16'd65535, 16'd1, 16'd1, 1'b0, 6'd0},
      '{16'd32768, 16'd16384, 16'd43690, 1'b0, 6'd0},
      '{16'd21845, 16'd43690, 16'd21846, 1'b0, 6'd0}
   };

   function automatic logic [5:0] vector_phases(input int v);
      logic [1:0] a, b, c;
      case (v)
         0: begin
            a = svp_pkg::PH_LOWER; b = svp_pkg::PH_LOWER; c = svp_pkg::PH_LOWER;
         end
         1: begin
            a = svp_pkg::PH_UPPER; b = svp_pkg::PH_LOWER; c = svp_pkg::PH_LOWER;
         end
         2: begin
            a = svp_pkg::PH_UPPER; b = svp_pkg::PH_UPPER; c = svp_pkg::PH_LOWER;
         end
         3: begin
            a = svp_pkg::PH_LOWER; b = svp_pkg::PH_UPPER; c = svp_pkg::PH_LOWER;
         end
         4: begin
            a = svp_pkg::PH_LOWER; b = svp_pkg::PH_UPPER; c = svp_pkg::PH_UPPER;
         end
         5: begin
            a = svp_pkg::PH_LOWER; b = svp_pkg::PH_LOWER; c = svp_pkg::PH_UPPER;
         end
         6: begin
            a = svp_pkg::PH_UPPER; b = svp_pkg::PH_LOWER; c = svp_pkg::PH_UPPER;
         end
         default: begin
            a = svp_pkg::PH_UPPER; b = svp_pkg::PH_UPPER; c = svp_pkg::PH_UPPER;
         end
      endcase
      return {c, b, a};
   endfunction

   // Taylor series to x^9 in Q30, rounded to Q15
   task automatic fill_sine();
      longint unsigned x, x2, term, sum;
      longint unsigned div [4] = '{6, 20, 42, 72};
      for (int k = 0; k <= svp_pkg::SINE_ENTRIES; k++) begin
         x = (longint'(k) * svp_pkg::PI3_Q30) / svp_pkg::SINE_ENTRIES;
         x2 = (x * x) >> 30;
         term = x;
         sum = x;
         for (int n = 0; n < 4; n++) begin
            term = ((term * x2) >> 30) / div[n];
            if (n % 2 == 0) sum = (sum >= term) ? sum - term : 64'd0;
            else sum = sum + term;
         end
         sine_q15[k] = 16'((sum + 64'd16384) >> 15);
      end
   endtask

   function automatic longint dwell_time(longint unsigned mag, longint unsigned s,
                                         longint unsigned n, longint unsigned dc);
      longint unsigned num;
      num = (2 * mag * s * n) << svp_pkg::TIME_FRAC_BITS;
      return longint'(num / (dc << 15));
   endfunction

   // advance the model by one tick and return the phases it emits
   function automatic logic [5:0] next_phases(input logic [15:0] dc_in,
                                              input logic [15:0] mag_in,
                                              input logic [15:0] ang);
      longint unsigned dc, mag, n, p, r, idx;
      int     sec, first, second, sel;
      longint tl, tr, tf, ts, t0, nq, tq, b1, b2, b3, b4, b5, b6, lim;
      dc = dc_in;
      mag = mag_in;
      n = mdl_period;
      sel = -1;
      if (mdl_tick > mdl_period) mdl_tick = '0;
      if (dc == 0) begin
         dc = 1;
         mag = 65535;
      end
      p = longint'(ang) * 6;
      sec = int'(p >> 16) + 1;
      r = p & 64'hFFFF;
      idx = (r * svp_pkg::SINE_ENTRIES) >> 16;
      tl = dwell_time(mag, sine_q15[idx], n, dc);
      tr = dwell_time(mag, sine_q15[svp_pkg::SINE_ENTRIES - idx], n, dc);
      if (sec % 2 == 1) begin
         first = sec; second = sec + 1; tf = tr; ts = tl;
      end else begin
         first = sec + 1; second = sec; tf = tl; ts = tr;
      end
      if (first >= 7) first = 1;
      if (second >= 7) second = 1;
      nq = longint'(n) << svp_pkg::TIME_FRAC_BITS;
      t0 = nq - tl - tr;
      b1 = t0;
      b2 = b1 + 2 * tf;
      b3 = b2 + 2 * ts;
      b4 = 3 * t0 + 2 * tf + 2 * ts;
      b5 = b4 + 2 * ts;
      b6 = 3 * t0 + 4 * tf + 4 * ts;
      lim = 4 * nq;
      tq = 4 * (longint'(mdl_tick) << svp_pkg::TIME_FRAC_BITS);
      // later segments win where overmodulation makes them overlap
      if (tq <= b1) sel = 0;
      if (tq > b1 && tq <= b2) sel = first;
      if (tq > b2 && tq <= b3) sel = second;
      if (tq > b3 && tq <= b4) sel = 7;
      if (tq > b4 && tq <= b5) sel = second;
      if (tq > b5 && tq <= b6) sel = first;
      if (tq > b6 && tq <= lim) sel = 0;
      if (sel >= 0) mdl_held = vector_phases(sel);
      mdl_tick = mdl_tick + 1'b1;
      return mdl_held;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // offer one tick; hold valid across back-to-back transactions
   task automatic send_tick(input logic [15:0] dc, input logic [15:0] mag,
                            input logic [15:0] ang);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {ang, mag, dc};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic run_tick(input logic [15:0] dc, input logic [15:0] mag,
                           input logic [15:0] ang);
      phase_queue.push_back(next_phases(dc, mag, ang));
      send_tick(dc, mag, ang);
   endtask

   // drain the block fully, then write the period register
   task automatic write_period(input logic [15:0] value);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (phase_queue.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      mdl_period = value;
   endtask

   task automatic random_tick();
      logic [15:0] dc, mag, ang;
      int roll;
      roll = $urandom_range(99);
      ang = 16'($urandom);
      if (roll < 5) begin
         dc = '0;
         mag = 16'($urandom);
      end else if (roll < 25) begin
         // noise: any magnitude, often overmodulated
         dc = 16'($urandom);
         mag = 16'($urandom);
      end else begin
         // linear range with random content
         dc = 16'($urandom_range(65535, 256));
         mag = 16'($urandom_range(dc / 2));
      end
      run_tick(dc, mag, ang);
   endtask

   // receiver: random idling, plus one long hold-off on request
   always @(posedge clock) begin
      static int hold_cycles = 0;
      logic [5:0] want;
      if (rsp_tvalid && rsp_tready) begin
         if (phase_queue.size() == 0) begin
            report_mismatch("unexpected transaction", rsp_tdata, 0);
         end else begin
            want = phase_queue.pop_front();
            if (rsp_tdata[1:0] != want[1:0])
               report_mismatch("phase_a", rsp_tdata[1:0], want[1:0]);
            if (rsp_tdata[3:2] != want[3:2])
               report_mismatch("phase_b", rsp_tdata[3:2], want[3:2]);
            if (rsp_tdata[5:4] != want[5:4])
               report_mismatch("phase_c", rsp_tdata[5:4], want[5:4]);
         end
      end
      if (hold_request && hold_cycles == 0) hold_cycles = 400;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles--;
         if (hold_cycles == 0) hold_request = 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin
      #25_000_000;
      $display("FAIL space_vector_pwm_top");
      $finish;
   end

   initial begin
      logic [15:0] periods [6] = '{16'd1, 16'd0, 16'd7, 16'd65535, 16'd23, 16'd100};
      int per_phase [6] = '{120, 100, 150, 60, 260, 250};
      int sent;
      tick_row_type row;
      logic [5:0] got_model;
      fill_sine();
      mdl_period = svp_pkg::PERIOD_RESET;
      mdl_tick = '0;
      mdl_held = {svp_pkg::PH_NONE, svp_pkg::PH_NONE, svp_pkg::PH_NONE};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 34;
      recv_idle_pct = 76;
      foreach (directed[i]) begin
         row = directed[i];
         got_model = next_phases(row.dc, row.mag, row.ang);
         // typed rows carry their own answer; others use the model
         phase_queue.push_back(row.has_exp ? row.exp : got_model);
         send_tick(row.dc, row.mag, row.ang);
      end

      sent = 0;
      foreach (periods[p]) begin
         write_period(periods[p]);
         for (int k = 0; k < per_phase[p]; k++) begin
            if (sent == 320) begin
               send_idle_pct = 76;
               recv_idle_pct = 34;
            end
            if (sent == 640) begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
            // stall the receiver while the sender keeps offering
            if (sent == 700) hold_request = 1'b1;
            random_tick();
            sent++;
         end
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (phase_queue.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS space_vector_pwm_top");
      end else begin
         $display("FAIL space_vector_pwm_top");
      end
      $finish;
   end

endmodule
